/* rtl/glr_pkg.sv */
// shared types, constants and helpers for the gradient line rasterizer
`default_nettype none

package glr_pkg;

	localparam int COORD_BITS = 13;
	localparam int FRAME_BITS = 12;
	localparam int ERR_BITS   = COORD_BITS + 2;
	localparam int SHADE_BITS = 8;

	// action codes
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FRAME_BITS-1:0] FRAME_RESET = FRAME_BITS'(800);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0]        len_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;

	// command handed from the front to the back
	typedef struct packed {
		logic   is_load;
		coord_t origin_x;
		coord_t origin_y;
		coord_t target_x;
		coord_t target_y;
		len_t   delta_x;
		len_t   delta_y;
		logic   step_x_neg;
		logic   step_y_neg;
		logic   x_major;
		err_t   err_init;
		logic   active;
	} cmd_t;

	function automatic len_t abs_diff(input coord_t a, input coord_t b);
		logic signed [COORD_BITS:0] d;
		logic signed [COORD_BITS:0] n;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		n = -d;
		return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/glr_front.sv */
// front end: classifies input items and precomputes line setup
`default_nettype none

module glr_front (
	input  wire logic                   action,
	input  wire glr_pkg::coord_t        x_start,
	input  wire glr_pkg::coord_t        y_start,
	input  wire glr_pkg::coord_t        x_end,
	input  wire glr_pkg::coord_t        y_end,
	output glr_pkg::cmd_t               cmd
);

	glr_pkg::len_t dx;
	glr_pkg::len_t dy;
	logic          x_major;

	assign dx      = glr_pkg::abs_diff(x_end, x_start);
	assign dy      = glr_pkg::abs_diff(y_end, y_start);
	assign x_major = dx > dy;

	always_comb begin
		cmd            = '0;
		cmd.is_load    = (action == glr_pkg::ACT_START);
		cmd.origin_x   = x_start;
		cmd.origin_y   = y_start;
		cmd.target_x   = x_end;
		cmd.target_y   = y_end;
		cmd.delta_x    = dx;
		cmd.delta_y    = dy;
		cmd.step_x_neg = !(x_start < x_end);
		cmd.step_y_neg = !(y_start < y_end);
		cmd.x_major    = x_major;
		// half the major delta, negative when y leads
		if (x_major) begin
			cmd.err_init = glr_pkg::err_t'({2'b00, dx >> 1});
		end else begin
			cmd.err_init = -glr_pkg::err_t'({2'b00, dy >> 1});
		end
		cmd.active     = (x_start != x_end) || (y_start != y_end);
	end

endmodule

`default_nettype wire

/* rtl/glr_fifo.sv */
// small command queue between front and back
`default_nettype none

module glr_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output logic [W-1:0]      rd_data,
	output logic              valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == FULL_CNT);
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a write");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers differ on empty queue");

endmodule

`default_nettype wire

/* rtl/glr_back.sv */
// back end: line stepper, shade divider and result register
`default_nettype none

module glr_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [glr_pkg::FRAME_BITS-1:0] cfg_data,
	input  wire logic                          cmd_valid,
	input  wire glr_pkg::cmd_t                 cmd,
	output logic                               cmd_pop,
	output logic                               empty,
	input  wire logic                          pop,
	output glr_pkg::coord_t                    pixel_x,
	output glr_pkg::coord_t                    pixel_y,
	output logic                               in_frame,
	output logic [glr_pkg::SHADE_BITS-1:0]     shade,
	output logic                               last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam int CB = glr_pkg::COORD_BITS;
	localparam int DIV_STEPS = glr_pkg::SHADE_BITS;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_STEPS - 1);

	logic [glr_pkg::FRAME_BITS-1:0] frame_width_q;
	logic [glr_pkg::FRAME_BITS-1:0] frame_height_q;

	glr_pkg::coord_t cur_x_q, cur_y_q, origin_x_q, origin_y_q, target_x_q, target_y_q;
	glr_pkg::len_t   delta_x_q, delta_y_q;
	logic            step_x_neg_q, step_y_neg_q, x_major_q, active_q;
	glr_pkg::err_t   err_q;

	logic [1:0]                     state_q;
	logic [CNT_BITS-1:0]            cnt_q;
	glr_pkg::len_t                  rem_q;
	glr_pkg::len_t                  len_q;
	logic [glr_pkg::SHADE_BITS-1:0] quo_q;
	glr_pkg::coord_t                pend_x_q, pend_y_q;
	logic                           pend_in_q, pend_last_q;

	logic                           out_valid_q;
	glr_pkg::coord_t                out_x_q, out_y_q;
	logic                           out_in_q, out_last_q;
	logic [glr_pkg::SHADE_BITS-1:0] out_shade_q;

	// pixel step
	glr_pkg::err_t   neg_dx, pos_dx, pos_dy;
	logic            step_x, step_y;
	glr_pkg::err_t   err_next;
	glr_pkg::coord_t nx, ny;
	logic            last_now, inside_now;
	glr_pkg::len_t   dist_now, len_now;
	logic [CB:0]     rem_dbl;
	logic            rem_ge;
	logic [CB:0]     rem_sub;
	logic            out_write;

	assign pos_dx = glr_pkg::err_t'({2'b00, delta_x_q});
	assign pos_dy = glr_pkg::err_t'({2'b00, delta_y_q});
	assign neg_dx = -pos_dx;
	assign step_x = err_q > neg_dx;
	assign step_y = err_q < pos_dy;

	always_comb begin
		err_next = err_q;
		nx       = cur_x_q;
		ny       = cur_y_q;
		if (step_x) begin
			err_next = err_next - pos_dy;
			nx       = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (step_y) begin
			err_next = err_next + pos_dx;
			ny       = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
	end

	assign last_now   = (nx == target_x_q) && (ny == target_y_q);
	assign inside_now = !cur_x_q[CB-1] && !cur_y_q[CB-1]
		&& (cur_x_q[CB-2:0] < frame_width_q) && (cur_y_q[CB-2:0] < frame_height_q);
	assign dist_now   = x_major_q ? glr_pkg::abs_diff(cur_x_q, origin_x_q)
		: glr_pkg::abs_diff(cur_y_q, origin_y_q);
	assign len_now    = x_major_q ? delta_x_q : delta_y_q;

	assign rem_dbl = {rem_q, 1'b0};
	assign rem_ge  = rem_dbl >= {1'b0, len_q};
	assign rem_sub = rem_dbl - {1'b0, len_q};

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign out_write = (state_q == ST_DONE) && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= glr_pkg::FRAME_RESET;
			frame_height_q <= glr_pkg::FRAME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				glr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				glr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_write) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.is_load) begin
							active_q <= cmd.active;
						end else if (active_q) begin
							if (last_now) begin
								active_q <= 1'b0;
							end
							cnt_q <= '0;
							// at or past the end the shade saturates
							state_q <= (dist_now >= len_now) ? ST_DONE : ST_DIV;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_write) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// line state, divider and result data
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			if (cmd.is_load) begin
				origin_x_q   <= cmd.origin_x;
				origin_y_q   <= cmd.origin_y;
				target_x_q   <= cmd.target_x;
				target_y_q   <= cmd.target_y;
				cur_x_q      <= cmd.origin_x;
				cur_y_q      <= cmd.origin_y;
				delta_x_q    <= cmd.delta_x;
				delta_y_q    <= cmd.delta_y;
				step_x_neg_q <= cmd.step_x_neg;
				step_y_neg_q <= cmd.step_y_neg;
				x_major_q    <= cmd.x_major;
				err_q        <= cmd.err_init;
			end else if (active_q) begin
				pend_x_q    <= cur_x_q;
				pend_y_q    <= cur_y_q;
				pend_in_q   <= inside_now;
				pend_last_q <= last_now;
				rem_q       <= dist_now;
				len_q       <= len_now;
				quo_q       <= '1;
				cur_x_q     <= nx;
				cur_y_q     <= ny;
				err_q       <= err_next;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_ge ? rem_sub[CB-1:0] : rem_dbl[CB-1:0];
			quo_q <= {quo_q[glr_pkg::SHADE_BITS-2:0], rem_ge};
		end
		if (out_write) begin
			out_x_q     <= pend_x_q;
			out_y_q     <= pend_y_q;
			out_in_q    <= pend_in_q;
			out_last_q  <= pend_last_q;
			out_shade_q <= quo_q;
		end
	end

	assign empty    = !out_valid_q;
	assign pixel_x  = out_x_q;
	assign pixel_y  = out_y_q;
	assign in_frame = out_in_q;
	assign shade    = out_shade_q;
	assign last     = out_last_q;

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < len_q))
		else $error("divider remainder not below divisor");

	a_active_len: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && state_q == ST_IDLE) |-> (len_now != '0))
		else $error("active line with zero major length");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !pop) |=> (state_q == ST_DONE))
		else $error("result left done state with result register busy");

	a_no_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd_pop)
		else $error("command taken while a pixel is in flight");

endmodule

`default_nettype wire

/* rtl/gradient_line_rasterizer_top.sv */
// top level of the gradient line rasterizer
`default_nettype none

// Bresenham line stepper with clip flag and 8-bit gradient shade.
// input channel: push/full; a transfer happens when push is high and full low.
//   action 0 loads a line from x_start/y_start/x_end/y_end, action 1 asks
//   for the next pixel. items go through a setup front end into a command
//   queue of CMD_DEPTH entries, so the input keeps taking items while the
//   stepper works or waits on the output.
// result channel: empty/pop; the oldest pixel is on the ports while empty is
//   low and leaves with a transfer when pop is high.
// pixel path: an advance passes the command queue, the stepper, the shade
//   divider and the result register; a saturated shade skips the divider.
// stepper: a start or a dead advance leaves it idle; a pixel runs through the
//   bit-per-cycle shade divider (8 steps) and waits in the done state until
//   the result register is free, and only then is the next item taken.
// config: cfg_we/cfg_index/cfg_data write frame_width (0) and frame_height (1);
//   write them only while the block is idle, which the block does not enforce.
// reset: arst_n clears the queue and result register, drops any line and
//   sets both frame sizes to 800.
// when the receiver stalls, the finished pixel waits in the result register,
//   the stepper then holds, and once the queue fills full rises.
module gradient_line_rasterizer_top #(
	parameter int CMD_DEPTH = 2
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [glr_pkg::FRAME_BITS-1:0] cfg_data,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic                           action,
	input  wire glr_pkg::coord_t                x_start,
	input  wire glr_pkg::coord_t                y_start,
	input  wire glr_pkg::coord_t                x_end,
	input  wire glr_pkg::coord_t                y_end,
	output logic                                empty,
	input  wire logic                           pop,
	output glr_pkg::coord_t                     pixel_x,
	output glr_pkg::coord_t                     pixel_y,
	output logic                                in_frame,
	output logic [glr_pkg::SHADE_BITS-1:0]      shade,
	output logic                                last
);

	localparam int CMD_W = $bits(glr_pkg::cmd_t);

	glr_pkg::cmd_t  front_cmd;   // classified item from the front end
	glr_pkg::cmd_t  back_cmd;    // head of the command queue
	logic [CMD_W-1:0] q_rd_data;
	logic           q_valid;
	logic           q_pop;

	// setup: deltas, directions and start error
	glr_front u_front (
		.action  (action),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.cmd     (front_cmd)
	);

	// decouples the input transfer from the stepper
	glr_fifo #(
		.W     (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.valid   (q_valid)
	);

	assign back_cmd = glr_pkg::cmd_t'(q_rd_data);

	// stepper, shade divider and result register
	glr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (q_valid),
		.cmd       (back_cmd),
		.cmd_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.in_frame  (in_frame),
		.shade     (shade),
		.last      (last)
	);

endmodule

`default_nettype wire

/* tb/gradient_line_rasterizer_top_tb.sv */
// self-checking testbench for the gradient line rasterizer top level
`default_nettype none

module gradient_line_rasterizer_top_tb;

	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 10;
	localparam int DRAIN_CYCLES    = 40;    // covers the pixel path plus queued dead items
	localparam int WATCHDOG_LIMIT  = 4000;  // longest quiet stretch is the long output hold
	localparam int LONG_HOLD       = 400;
	localparam int RANDOM_ITEMS    = 1300;

	// one pixel as the block hands it out
	typedef struct {
		glr_pkg::coord_t                x;
		glr_pkg::coord_t                y;
		logic                           in_frame;
		logic [glr_pkg::SHADE_BITS-1:0] shade;
		logic                           last;
	} pixel_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic                           cfg_index;
	logic [glr_pkg::FRAME_BITS-1:0] cfg_data;
	logic                           push;
	logic                           full;
	logic                           action;
	glr_pkg::coord_t                x_start;
	glr_pkg::coord_t                y_start;
	glr_pkg::coord_t                x_end;
	glr_pkg::coord_t                y_end;
	logic                           empty;
	logic                           pop;
	glr_pkg::coord_t                pixel_x;
	glr_pkg::coord_t                pixel_y;
	logic                           in_frame;
	logic [glr_pkg::SHADE_BITS-1:0] shade;
	logic                           last;

	gradient_line_rasterizer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.action   (action),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.empty    (empty),
		.pop      (pop),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.in_frame (in_frame),
		.shade    (shade),
		.last     (last)
	);

	// line stepper state mirrored on the testbench side
	glr_pkg::coord_t                org_x, org_y, end_x, end_y, pos_x, pos_y;
	int                             span_x, span_y;
	bit                             back_x, back_y;
	int                             bres_err;
	bit                             line_live;
	logic [glr_pkg::FRAME_BITS-1:0] frame_w, frame_h;

	pixel_t pixels_due[$];  // pixels predicted but not yet seen on the result side
	int     mismatches;
	int     items_sent;
	bit     sender_gaps;
	bit     receiver_gaps;
	int     hold_left;      // long output hold, counted down by the receiver

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void load_line(input glr_pkg::coord_t xs, input glr_pkg::coord_t ys,
			input glr_pkg::coord_t xe, input glr_pkg::coord_t ye);
		org_x  = xs;
		org_y  = ys;
		end_x  = xe;
		end_y  = ye;
		pos_x  = xs;
		pos_y  = ys;
		span_x = (int'(xe) > int'(xs)) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
		span_y = (int'(ye) > int'(ys)) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
		back_x = !(xs < xe);
		back_y = !(ys < ye);
		// sv integer division truncates toward zero, as the stepper does
		bres_err  = (span_x > span_y ? span_x : -span_y) / 2;
		// a zero-length line never goes live
		line_live = (xs != xe) || (ys != ye);
	endfunction

	// emits the current pixel and takes one bresenham step; 0 when no line is live
	function automatic bit advance_line(output pixel_t px);
		int e;
		int gap;
		int len;
		int sh;
		px = '{default: '0};
		if (!line_live)
			return 1'b0;
		px.x = pos_x;
		px.y = pos_y;
		px.in_frame = (pos_x >= 0) && (pos_y >= 0) &&
			(int'(pos_x) < int'(frame_w)) && (int'(pos_y) < int'(frame_h));
		// shade runs along the major axis; ties count as y major
		if (span_x > span_y) begin
			gap = int'(pos_x) - int'(org_x);
			len = span_x;
		end else begin
			gap = int'(pos_y) - int'(org_y);
			len = span_y;
		end
		if (gap < 0)
			gap = -gap;
		sh = (len > 0) ? (gap * 256) / len : 0;
		if (sh > 255)
			sh = 255;
		px.shade = sh[glr_pkg::SHADE_BITS-1:0];
		e = bres_err;
		if (e > -span_x) begin
			bres_err -= span_y;
			pos_x = back_x ? pos_x - 13'sd1 : pos_x + 13'sd1;
		end
		if (e < span_y) begin
			bres_err += span_x;
			pos_y = back_y ? pos_y - 13'sd1 : pos_y + 13'sd1;
		end
		// the end point itself is never emitted; the pixel before it is marked last
		px.last = (pos_x == end_x) && (pos_y == end_y);
		if (px.last)
			line_live = 1'b0;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- input side

	// one input transfer; the predictor runs on the edge that accepts it
	task automatic send_item(input logic act, input glr_pkg::coord_t xs,
			input glr_pkg::coord_t ys, input glr_pkg::coord_t xe,
			input glr_pkg::coord_t ye);
		pixel_t px;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push    <= 1'b1;
		action  <= act;
		x_start <= xs;
		y_start <= ys;
		x_end   <= xe;
		y_end   <= ye;
		do @(posedge clk); while (full !== 1'b0);
		if (act == glr_pkg::ACT_START)
			load_line(xs, ys, xe, ye);
		else if (advance_line(px))
			pixels_due.push_back(px);
		items_sent++;
	endtask

	function automatic glr_pkg::coord_t rand_coord();
		return glr_pkg::coord_t'($urandom);
	endfunction

	task automatic send_start(input int xs, input int ys, input int xe, input int ye);
		send_item(glr_pkg::ACT_START, glr_pkg::coord_t'(xs), glr_pkg::coord_t'(ys),
			glr_pkg::coord_t'(xe), glr_pkg::coord_t'(ye));
	endtask

	// endpoint fields are don't-care on an advance, so they carry noise
	task automatic send_advance();
		send_item(glr_pkg::ACT_ADVANCE, rand_coord(), rand_coord(), rand_coord(),
			rand_coord());
	endtask

	// stop sending and let every queued item work its way out
	task automatic wait_drained();
		push <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_frame_reg(input logic idx,
			input logic [glr_pkg::FRAME_BITS-1:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == glr_pkg::REG_FRAME_WIDTH)
			frame_w = val;
		else
			frame_h = val;
	endtask

	// base plus offset, mirrored when that would leave the coordinate range
	function automatic int offset_coord(input int base, input int d);
		int v;
		v = base + d;
		if (v > 4095 || v < -4096)
			v = base - d;
		return v;
	endfunction

	// a random line followed by advances; mostly run to just past the end,
	// sometimes cut short by the next start, now and then pure noise
	task automatic draw_random_line();
		int kind;
		int ox, oy, tx, ty;
		int len, n;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			send_item(logic'($urandom_range(0, 1)), rand_coord(), rand_coord(),
				rand_coord(), rand_coord());
			return;
		end
		if (kind == 1) begin
			// long line with a wide divisor, dropped part way
			send_item(glr_pkg::ACT_START, rand_coord(), rand_coord(), rand_coord(),
				rand_coord());
			repeat ($urandom_range(1, 20)) send_advance();
			return;
		end
		// start near a frame edge half the time so clipping flips along the line
		if ($urandom_range(0, 1) == 0) begin
			ox = offset_coord($urandom_range(0, 1) ? int'(frame_w) : 0,
				$urandom_range(0, 24) - 12);
			oy = offset_coord($urandom_range(0, 1) ? int'(frame_h) : 0,
				$urandom_range(0, 24) - 12);
		end else begin
			ox = int'(rand_coord());
			oy = int'(rand_coord());
		end
		tx  = offset_coord(ox, $urandom_range(0, 48) - 24);
		ty  = offset_coord(oy, $urandom_range(0, 48) - 24);
		len = (tx > ox ? tx - ox : ox - tx);
		if ((ty > oy ? ty - oy : oy - ty) > len)
			len = (ty > oy ? ty - oy : oy - ty);
		if ($urandom_range(0, 5) == 0)
			n = $urandom_range(0, len);
		else
			n = len + $urandom_range(0, 2);
		send_start(ox, oy, tx, ty);
		repeat (n) send_advance();
	endtask

	task automatic random_frame_phase(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at)
			draw_random_line();
	endtask

	// ---------------------------------------------------------------- result side

	function automatic void compare_field(input string name,
			input logic signed [31:0] want, input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// pops with random stalls and the long hold, checks each transfer against
	// the oldest predicted pixel
	initial begin : result_side
		pixel_t want;
		int     stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (pop === 1'b1 && empty === 1'b0) begin
				if (pixels_due.size() == 0) begin
					$display("%0t: pixel (%0d, %0d) with none expected",
						$time, pixel_x, pixel_y);
					mismatches++;
				end else begin
					want = pixels_due.pop_front();
					compare_field("pixel_x", want.x, pixel_x);
					compare_field("pixel_y", want.y, pixel_y);
					compare_field("in_frame", {31'd0, want.in_frame}, {31'd0, in_frame});
					compare_field("shade", {24'd0, want.shade}, {24'd0, shade});
					compare_field("last", {31'd0, want.last}, {31'd0, last});
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 12);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// ends the run when nothing moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("FAIL gradient_line_rasterizer_top");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// corner cases at the reset frame size of 800 x 800
	task automatic test_directed_lines();
		// advance with no line loaded yet
		send_advance();
		// zero-length line stays inactive
		send_start(5, 5, 5, 5);
		send_advance();
		// longest anti-diagonal from the coordinate extremes, dropped after a few pixels
		send_start(-4096, 4095, 4095, -4096);
		repeat (3) send_advance();
		// shallow line crossing the right edge, plus one advance past its end
		send_start(797, 2, 801, 0);
		repeat (5) send_advance();
		// steep line leaving the left edge
		send_start(0, 0, -2, 5);
		repeat (6) send_advance();
		// exact diagonal through the top edge
		send_start(3, -1, 0, 2);
		repeat (4) send_advance();
	endtask

	// zero clips everything, one leaves a single pixel, 4095 is the widest frame
	task automatic test_frame_limits();
		write_frame_reg(glr_pkg::REG_FRAME_WIDTH, '0);
		write_frame_reg(glr_pkg::REG_FRAME_HEIGHT, '1);
		random_frame_phase(60);
		write_frame_reg(glr_pkg::REG_FRAME_WIDTH, '1);
		write_frame_reg(glr_pkg::REG_FRAME_HEIGHT, '0);
		random_frame_phase(60);
		write_frame_reg(glr_pkg::REG_FRAME_WIDTH, glr_pkg::FRAME_BITS'(1));
		write_frame_reg(glr_pkg::REG_FRAME_HEIGHT, glr_pkg::FRAME_BITS'(1));
		random_frame_phase(60);
	endtask

	task automatic test_random_lines();
		repeat (6) begin
			write_frame_reg(glr_pkg::REG_FRAME_WIDTH,
				glr_pkg::FRAME_BITS'($urandom_range(1, 4095)));
			write_frame_reg(glr_pkg::REG_FRAME_HEIGHT,
				glr_pkg::FRAME_BITS'($urandom_range(1, 4095)));
			random_frame_phase(RANDOM_ITEMS / 12);
		end
	endtask

	// hold the output off for a long stretch while a long line keeps coming,
	// so the command queue fills and full has to stall the input
	task automatic test_output_backpressure();
		write_frame_reg(glr_pkg::REG_FRAME_WIDTH, glr_pkg::FRAME_RESET);
		write_frame_reg(glr_pkg::REG_FRAME_HEIGHT, glr_pkg::FRAME_RESET);
		hold_left = LONG_HOLD;
		send_start(-20, 790, 80, 827);
		repeat (101) send_advance();
	endtask

	// no idling anywhere for the tail of the run
	task automatic test_full_rate();
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		random_frame_phase(200);
	endtask

	initial begin : stimulus
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = glr_pkg::REG_FRAME_WIDTH;
		cfg_data      = '0;
		push          = 1'b0;
		pop           = 1'b0;
		action        = glr_pkg::ACT_START;
		x_start       = '0;
		y_start       = '0;
		x_end         = '0;
		y_end         = '0;
		mismatches    = 0;
		items_sent    = 0;
		hold_left     = 0;
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		load_line('0, '0, '0, '0);
		frame_w = glr_pkg::FRAME_RESET;
		frame_h = glr_pkg::FRAME_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lines();
		test_frame_limits();
		test_random_lines();
		test_output_backpressure();
		test_full_rate();

		wait_drained();
		if (mismatches == 0 && pixels_due.size() == 0)
			$display("PASS gradient_line_rasterizer_top");
		else
			$display("FAIL gradient_line_rasterizer_top");
		$finish;
	end

endmodule

`default_nettype wire
